/* hw/rtl/nfe_pkg.sv */
// Package for the NFLOG to Ethernet rewriter: beat and descriptor types,
// parser phases, register indexes and the Ethernet header byte table.
// No dependencies.
package nfe_pkg;

  localparam int unsigned MacW    = 48;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSrcMac = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDstMac = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBypass = 2'd2;

  localparam logic [MacW-1:0] SrcMacRst = 48'h1111_1111_1111;
  localparam logic [MacW-1:0] DstMacRst = 48'h2222_2222_2222;

  localparam logic [15:0] PayloadType = 16'h0009;
  localparam logic [15:0] MinTlvLen   = 16'd4;
  localparam logic [16:0] TlvHdrLen   = 17'd4;
  localparam logic [16:0] AlignAdd    = 17'd3;
  localparam logic [16:0] AlignMask   = 17'h1_FFFC;

  localparam logic [7:0]  FamIpv4  = 8'd2;
  localparam logic [7:0]  FamIpv6  = 8'd10;
  localparam logic [15:0] EthIpv4  = 16'h0800;
  localparam logic [15:0] EthIpv6  = 16'h86DD;

  localparam logic [3:0]  HdrLastCnt = 4'd13;

  typedef enum logic [2:0] {
    PH_HDR  = 3'd0,
    PH_TLV  = 3'd1,
    PH_SKIP = 3'd2,
    PH_PASS = 3'd3,
    PH_DROP = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_ERR  = 2'd1,
    KIND_HDR  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       malformed;
  } out_beat_t;

  // One pending result: a plain byte, an error beat or a full header
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
    logic [7:0] family;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } desc_bus_t;

  function automatic logic [7:0] eth_hdr_byte(input logic [3:0]      cnt,
                                              input logic [MacW-1:0] dst,
                                              input logic [MacW-1:0] src,
                                              input logic [7:0]      fam);
    logic [15:0] etype;
    logic [7:0]  res;
    if (fam == FamIpv4) begin
      etype = EthIpv4;
    end else if (fam == FamIpv6) begin
      etype = EthIpv6;
    end else begin
      etype = {8'h00, fam};
    end
    case (cnt)
      4'd0:    res = dst[47:40];
      4'd1:    res = dst[39:32];
      4'd2:    res = dst[31:24];
      4'd3:    res = dst[23:16];
      4'd4:    res = dst[15:8];
      4'd5:    res = dst[7:0];
      4'd6:    res = src[47:40];
      4'd7:    res = src[39:32];
      4'd8:    res = src[31:24];
      4'd9:    res = src[23:16];
      4'd10:   res = src[15:8];
      4'd11:   res = src[7:0];
      4'd12:   res = etype[15:8];
      4'd13:   res = etype[7:0];
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

/* hw/rtl/nfe_stream_if.sv */
// Valid/ready stream interface carrying one payload beat.
// Payload type is set per instance; used with types from nfe_pkg.
interface nfe_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/nfe_parser.sv */
// NFLOG/TLV parser: walks the header and TLV chain one byte per beat and
// posts a result descriptor into its output register. Depends on nfe_pkg.
module nfe_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  nfe_stream_if.sink        in_i,
  input  logic              bypass_i,
  input  logic              desc_take_i,
  output nfe_pkg::desc_bus_t desc_o
);
  import nfe_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  idx_q, idx_d;
  logic [7:0]  family_q, family_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  type_lo_q, type_lo_d;
  logic [16:0] skip_q, skip_d;

  logic        desc_valid_q;
  desc_t       desc_q;

  logic        in_rdy, accept;
  logic [7:0]  b;
  logic        last;
  logic [15:0] tlv_id;
  logic        tlv_end, is_payload;
  logic [16:0] skip_len;

  logic        emit;
  desc_t       emit_desc;

  assign in_rdy     = !desc_valid_q || desc_take_i;
  assign in_i.ready = in_rdy;
  assign accept     = in_i.valid && in_rdy;
  assign b          = in_i.data.in_byte;
  assign last       = in_i.data.in_last;

  assign tlv_id     = {b, type_lo_q};
  assign tlv_end    = (phase_q == PH_TLV) && (idx_q == 2'd3);
  assign is_payload = tlv_end && (tlv_id == PayloadType);
  // body bytes left after the 4-byte TLV header, length rounded up to 4
  assign skip_len   = ((({1'b0, len_q}) + AlignAdd) & AlignMask) - TlvHdrLen;

  // Next state
  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    family_d  = family_q;
    len_lo_d  = len_lo_q;
    len_d     = len_q;
    type_lo_d = type_lo_q;
    skip_d    = skip_q;
    if (bypass_i) begin
      phase_d = PH_HDR;
      idx_d   = 2'd0;
    end else begin
      case (phase_q)
        PH_HDR: begin
          if (idx_q == 2'd0) family_d = b;
          if (idx_q == 2'd3) begin
            phase_d = PH_TLV;
            idx_d   = 2'd0;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
        PH_TLV: begin
          idx_d = idx_q + 2'd1;
          case (idx_q)
            2'd0: len_lo_d  = b;
            2'd1: len_d     = {b, len_lo_q};
            2'd2: type_lo_d = b;
            default: begin
              if (is_payload) begin
                phase_d = PH_PASS;
              end else if (len_q < MinTlvLen) begin
                phase_d = PH_DROP;
              end else begin
                skip_d  = skip_len;
                phase_d = (skip_len == '0) ? PH_TLV : PH_SKIP;
              end
            end
          endcase
        end
        PH_SKIP: begin
          skip_d = skip_q - 17'd1;
          if (skip_q == 17'd1) begin
            phase_d = PH_TLV;
            idx_d   = 2'd0;
          end
        end
        default: ;
      endcase
      if (last) begin
        phase_d = PH_HDR;
        idx_d   = 2'd0;
      end
    end
  end

  // Result descriptor
  always_comb begin
    emit             = 1'b0;
    emit_desc.kind   = KIND_BYTE;
    emit_desc.data   = b;
    emit_desc.last   = last;
    emit_desc.family = family_q;
    if (bypass_i || (phase_q == PH_PASS)) begin
      emit = 1'b1;
    end else if (is_payload) begin
      emit           = 1'b1;
      emit_desc.kind = KIND_HDR;
    end else if (last) begin
      emit           = 1'b1;
      emit_desc.kind = KIND_ERR;
      emit_desc.data = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR;
      idx_q     <= 2'd0;
      family_q  <= 8'h00;
      len_lo_q  <= 8'h00;
      len_q     <= 16'h0000;
      type_lo_q <= 8'h00;
      skip_q    <= 17'h0;
    end else if (accept) begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      family_q  <= family_d;
      len_lo_q  <= len_lo_d;
      len_q     <= len_d;
      type_lo_q <= type_lo_d;
      skip_q    <= skip_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_valid_q <= 1'b0;
    end else if (accept && emit) begin
      desc_valid_q <= 1'b1;
    end else if (desc_take_i) begin
      desc_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) desc_q <= emit_desc;
  end

  assign desc_o.valid = desc_valid_q;
  assign desc_o.desc  = desc_q;

`ifndef SYNTHESIS
  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SKIP |-> skip_q != 17'h0)
    else $error("skip phase with nothing left to skip");

  a_bypass_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && bypass_i |=> phase_q == PH_HDR && idx_q == 2'd0)
    else $error("bypass beat did not restart the parser");

  a_desc_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_valid_q && !desc_take_i |=> desc_valid_q && $stable(desc_q))
    else $error("pending descriptor lost or changed");
`endif

endmodule

/* hw/rtl/nfe_emitter.sv */
// Output sequencer: turns descriptors into beats, expanding a header
// descriptor into 14 Ethernet header bytes. Depends on nfe_pkg.
module nfe_emitter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nfe_pkg::desc_bus_t            desc_i,
  output logic                          desc_take_o,
  input  logic [nfe_pkg::MacW-1:0]      dst_mac_i,
  input  logic [nfe_pkg::MacW-1:0]      src_mac_i,
  nfe_stream_if.source                  out_o
);
  import nfe_pkg::*;

  logic       out_valid_q, out_valid_d;
  out_beat_t  out_q, out_d;
  logic       busy_q, busy_d;
  logic [3:0] cnt_q, cnt_d;
  logic [7:0] fam_q, fam_d;
  logic       hlast_q, hlast_d;
  logic       load;

  assign load = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    fam_d       = fam_q;
    hlast_d     = hlast_q;
    desc_take_o = 1'b0;
    if (load) begin
      if (busy_q) begin
        out_valid_d     = 1'b1;
        out_d.out_byte  = eth_hdr_byte(cnt_q, dst_mac_i, src_mac_i, fam_q);
        out_d.out_last  = hlast_q && (cnt_q == HdrLastCnt);
        out_d.malformed = 1'b0;
        cnt_d           = cnt_q + 4'd1;
        if (cnt_q == HdrLastCnt) busy_d = 1'b0;
      end else if (desc_i.valid) begin
        desc_take_o     = 1'b1;
        out_valid_d     = 1'b1;
        out_d.out_byte  = desc_i.desc.data;
        out_d.out_last  = desc_i.desc.last;
        out_d.malformed = 1'b0;
        case (desc_i.desc.kind)
          KIND_ERR: begin
            out_d.out_byte  = 8'h00;
            out_d.out_last  = 1'b1;
            out_d.malformed = 1'b1;
          end
          KIND_HDR: begin
            out_d.out_byte = eth_hdr_byte(4'd0, dst_mac_i, src_mac_i,
                                          desc_i.desc.family);
            out_d.out_last = 1'b0;
            busy_d         = 1'b1;
            cnt_d          = 4'd1;
            fam_d          = desc_i.desc.family;
            hlast_d        = desc_i.desc.last;
          end
          default: ;
        endcase
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      busy_q      <= 1'b0;
      cnt_q       <= 4'd0;
    end else begin
      out_valid_q <= out_valid_d;
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    fam_q   <= fam_d;
    hlast_q <= hlast_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef SYNTHESIS
  a_busy_has_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> out_valid_q && cnt_q != 4'd0 && cnt_q <= HdrLastCnt)
    else $error("header sequencer busy without a beat in flight");

  a_hdr_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && load && cnt_q == HdrLastCnt |=> !busy_q && !out_q.malformed)
    else $error("header sequencer overran its 14 bytes");

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !desc_take_o)
    else $error("descriptor taken in the middle of a header");
`endif

endmodule

/* hw/rtl/nflog_to_ethernet_rewriter_top.sv */
// Top level of the NFLOG to Ethernet rewriter: configuration registers,
// parser and output sequencer. Depends on nfe_pkg, nfe_stream_if,
// nfe_parser and nfe_emitter.
//
// Usage:
//   in_i carries captured packet bytes (in_byte, in_last on the final byte).
//   out_o carries the rewritten frame (out_byte, out_last, malformed).
//   Each NFLOG packet loses its 4-byte header and its TLVs up to the payload
//   TLV header; in their place 14 Ethernet header bytes are sent (dst MAC,
//   src MAC, ethertype from the family byte). A packet that ends before the
//   payload TLV, or carries a non-payload TLV shorter than 4 bytes, yields
//   one beat with malformed set, out_byte 0 and out_last 1.
//   Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i):
//   index 0 source MAC, 1 destination MAC, 2 bypass; write only when idle.
// Timing:
//   One input beat per cycle while in_i.ready is high. A result beat passes
//   the descriptor register, then the output register. The payload TLV
//   header expands to 14 output beats, one per cycle while out_o is ready,
//   from the header sequencer; meanwhile one more input beat is held in the
//   parser's descriptor register and in_i.ready stays low until the header
//   is done. When out_o stalls, the output register holds its beat and one
//   further result waits in the descriptor register before in_i.ready falls.
// Reset: MACs return to 11:11:11:11:11:11 / 22:22:22:22:22:22, bypass off,
//   parser at the start of a packet, no beats pending.
module nflog_to_ethernet_rewriter_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [nfe_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [nfe_pkg::MacW-1:0]         cfg_wdata_i,
  nfe_stream_if.sink                       in_i,
  nfe_stream_if.source                     out_o
);
  import nfe_pkg::*;

  logic [MacW-1:0] src_mac_q;
  logic [MacW-1:0] dst_mac_q;
  logic            bypass_q;

  desc_bus_t       desc;
  logic            desc_take;

  // Config registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_mac_q <= SrcMacRst;
      dst_mac_q <= DstMacRst;
      bypass_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSrcMac: src_mac_q <= cfg_wdata_i;
        CfgDstMac: dst_mac_q <= cfg_wdata_i;
        CfgBypass: bypass_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  nfe_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .bypass_i    (bypass_q),
    .desc_take_i (desc_take),
    .desc_o      (desc)
  );

  nfe_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_i      (desc),
    .desc_take_o (desc_take),
    .dst_mac_i   (dst_mac_q),
    .src_mac_i   (src_mac_q),
    .out_o       (out_o)
  );

endmodule
